FILE: design/vte_pkg.sv
// Shared constants and controller/datapath interface types for the VT52 terminal engine.
`default_nettype none
package vte_pkg;

  // Screen store geometry
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 32;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int CELL_W   = 9;              // reverse bit over character
  localparam int NSLOT    = 3;              // sweeps one byte may need
  localparam int SLOT_W   = $clog2(NSLOT + 1);

  // Stream word widths
  localparam int IN_W  = 24;
  localparam int OUT_W = 40;

  // Configuration register indexes
  localparam logic [2:0] CFG_COLS  = 3'd0;
  localparam logic [2:0] CFG_ROWS  = 3'd1;
  localparam logic [2:0] CFG_TABW  = 3'd2;
  localparam logic [2:0] CFG_TABOV = 3'd3;
  localparam logic [2:0] CFG_BSOV  = 3'd4;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] COORD_OFS = 8'h20;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // take the accepted word, latch plan
    logic clr_wr;     // clearing pass write
    logic tab_step;   // advance tab stop search
    logic tab_done;   // commit tab stop
    logic sw_start;   // load sweep counters from current slot
    logic fill_wr;    // fill one cell
    logic copy_rd;    // read copy source
    logic copy_wr;    // write copy destination
    logic slot_next;  // move to next slot
    logic out_load;   // load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_read;
    logic is_tab;
    logic tab_end;
    logic slot_en;
    logic slot_copy;
    logic slots_done;
    logic cell_last;
    logic clr_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: design/vt52_terminal_engine_core.sv
// Top level of the VT52 terminal engine: stream ports, configuration port, controller and datapath.
`default_nettype none
// VT52-style terminal engine with a 32 x 128 cell screen store (character and reverse bit).
// After reset the store is cleared to spaces, one cell a cycle, so s_axis_tready stays low
// until the clear ends; configuration writes are taken during that time. Each input word yields
// one result word. A cell read skips the screen work. Other bytes run their screen work
// through a single-port store at one cell a cycle for fills; line copies read and then write
// each cell, and each sweep starts with a setup step. A tab first searches its stop, one tab
// width a cycle. A new word is taken while the previous result still waits on m_axis_tready.
module vt52_terminal_engine_core import vte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [7:0]       cfg_data_i,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // data_byte[7:0], read_row[12:8], read_col[19:13]
  input  logic             s_axis_tuser,  // operation
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // cursor_col[6:0], cursor_row[11:7],
                                          // cursor_visible[12], escape_pending[13],
                                          // bell_pulse[14], fore_color_set[15],
                                          // back_color_set[16], color_value[24:17],
                                          // cell_char[32:25], cell_reverse[33]
);

  cmd_t  cmd;
  stat_t stat;

  vte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  vte_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_op_i    (s_axis_tuser),
    .in_byte_i  (s_axis_tdata[7:0]),
    .in_row_i   (s_axis_tdata[8 +: ROW_W]),
    .in_col_i   (s_axis_tdata[8 + ROW_W +: COL_W]),
    .out_data_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: design/vte_ctrl.sv
// Sequencing state machine of the VT52 terminal engine.
`default_nettype none
module vte_ctrl import vte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_TAB, ST_SLOT, ST_FILL, ST_CRD, ST_CWR, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  // first cycle after load, when the latched plan becomes visible
  logic   fresh_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SLOT;
        end
      end
      ST_TAB: begin
        if (stat_i.tab_end) begin
          cmd_o.tab_done = 1'b1;
          state_d        = ST_SLOT;
        end else begin
          cmd_o.tab_step = 1'b1;
        end
      end
      ST_SLOT: begin
        // read words skip the sweeps, tab words search their stop first
        if (fresh_q && stat_i.is_read) begin
          state_d = ST_DONE;
        end else if (fresh_q && stat_i.is_tab) begin
          state_d = ST_TAB;
        end else if (stat_i.slots_done) begin
          state_d = ST_DONE;
        end else if (!stat_i.slot_en) begin
          cmd_o.slot_next = 1'b1;
        end else begin
          cmd_o.sw_start = 1'b1;
          state_d        = stat_i.slot_copy ? ST_CRD : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (stat_i.cell_last) begin
          cmd_o.slot_next = 1'b1;
          state_d         = ST_SLOT;
        end
      end
      ST_CRD: begin
        cmd_o.copy_rd = 1'b1;
        state_d       = ST_CWR;
      end
      ST_CWR: begin
        cmd_o.copy_wr = 1'b1;
        if (stat_i.cell_last) begin
          cmd_o.slot_next = 1'b1;
          state_d         = ST_SLOT;
        end else begin
          state_d = ST_CRD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      fresh_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      fresh_q     <= cmd_o.load;
      state_q     <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/vte_datapath.sv
// Screen store, cursor and flag registers, and sweep counters of the VT52 terminal engine.
`default_nettype none
module vte_datapath import vte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_op_i,
  input  logic [7:0]        in_byte_i,
  input  logic [ROW_W-1:0]  in_row_i,
  input  logic [COL_W-1:0]  in_col_i,
  output logic [OUT_W-1:0]  out_data_o
);

  typedef enum logic [2:0] {
    ESC_GROUND, ESC_LETTER, ESC_ROW, ESC_COL, ESC_FORE, ESC_BACK
  } esc_e;

  typedef struct packed {
    logic             en;
    logic             copy;
    logic             down;    // copy from the row above, rows descending
    logic [ROW_W-1:0] ra;      // first row
    logic [ROW_W-1:0] rb;      // last row
    logic [COL_W-1:0] c0;
    logic [COL_W:0]   c1;      // exclusive
    logic [7:0]       ch;
    logic             rev;
  } slot_t;

  // Escape letters
  localparam logic [7:0] KEY_FORE    = "b";
  localparam logic [7:0] KEY_BACK    = "c";
  localparam logic [7:0] KEY_ADDR    = "Y";
  localparam logic [7:0] KEY_CLR_BOS = "d";
  localparam logic [7:0] KEY_CUR_ON  = "e";
  localparam logic [7:0] KEY_CUR_OFF = "f";
  localparam logic [7:0] KEY_SAVE    = "j";
  localparam logic [7:0] KEY_REST    = "k";
  localparam logic [7:0] KEY_CLR_LN  = "l";
  localparam logic [7:0] KEY_CLR_BOL = "o";
  localparam logic [7:0] KEY_REV_ON  = "p";
  localparam logic [7:0] KEY_REV_OFF = "q";
  localparam logic [7:0] KEY_WRAP_ON = "v";
  localparam logic [7:0] KEY_WRAP_OF = "w";
  localparam logic [7:0] KEY_UP      = "A";
  localparam logic [7:0] KEY_DOWN    = "B";
  localparam logic [7:0] KEY_RIGHT   = "C";
  localparam logic [7:0] KEY_LEFT    = "D";
  localparam logic [7:0] KEY_CLR_ALL = "E";
  localparam logic [7:0] KEY_HOME    = "H";
  localparam logic [7:0] KEY_REV_LF  = "I";
  localparam logic [7:0] KEY_CLR_EOS = "J";
  localparam logic [7:0] KEY_CLR_EOL = "K";
  localparam logic [7:0] KEY_INS_LN  = "L";
  localparam logic [7:0] KEY_DEL_LN  = "M";

  function automatic slot_t mk_slot(input logic en, input logic copy, input logic down,
                                    input logic [ROW_W-1:0] ra, input logic [ROW_W-1:0] rb,
                                    input logic [COL_W-1:0] c0, input logic [COL_W:0] c1,
                                    input logic [7:0] ch, input logic rev);
    slot_t s;
    s.en = en; s.copy = copy; s.down = down; s.ra = ra; s.rb = rb;
    s.c0 = c0; s.c1 = c1; s.ch = ch; s.rev = rev;
    return s;
  endfunction

  // ESC Y coordinate: byte minus offset, clamped to the window
  function automatic logic [7:0] clamp_coord(input logic [7:0] b, input logic [7:0] last);
    logic [7:0] v;
    v = b - COORD_OFS;
    if (b < COORD_OFS) return '0;
    return (v > last) ? last : v;
  endfunction

  // Configuration registers
  logic [7:0] cols_q, tabw_q;
  logic [5:0] rows_q;
  logic       tabov_q, bsov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= 8'd80;
      rows_q  <= 6'd25;
      tabw_q  <= 8'd8;
      tabov_q <= 1'b0;
      bsov_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLS:  cols_q  <= cfg_data_i;
        CFG_ROWS:  rows_q  <= cfg_data_i[5:0];
        CFG_TABW:  tabw_q  <= cfg_data_i;
        CFG_TABOV: tabov_q <= cfg_data_i[0];
        CFG_BSOV:  bsov_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective window
  logic [COL_W:0]   nc;
  logic [ROW_W:0]   nr;
  logic [COL_W-1:0] lc;
  logic [ROW_W-1:0] lr;
  logic [7:0]       tw;

  assign nc = (cols_q == '0) ? (COL_W+1)'(1) :
              (cols_q > 8'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS) : (COL_W+1)'(cols_q);
  assign nr = (rows_q == '0) ? (ROW_W+1)'(1) :
              (rows_q > 6'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(rows_q);
  assign lc = COL_W'(nc - 1'b1);
  assign lr = ROW_W'(nr - 1'b1);
  assign tw = (tabw_q == '0) ? 8'd1 : tabw_q;

  // Terminal state
  logic [COL_W-1:0] col_q, scol_q;
  logic [ROW_W-1:0] row_q, srow_q;
  logic             rev_on_q, wrap_q, shown_q;
  esc_e             esc_q;
  logic [7:0]       pend_q;
  logic             bell_q, fore_q, back_q, is_read_q, is_tab_q;
  logic [7:0]       color_q;
  slot_t            slot_q [NSLOT];
  logic [SLOT_W-1:0] idx_q;
  logic [ROW_W-1:0] swr_q;
  logic [COL_W-1:0] swc_q;
  logic [8:0]       acc_q;
  logic [CELL_W-1:0] rdata_q;
  logic [OUT_W-1:0] out_q;

  // Cursor brought back into the window
  logic [COL_W-1:0] fc, kc;
  logic [ROW_W-1:0] fr, kr;

  always_comb begin
    fr = (row_q > lr) ? lr : row_q;
    fc = (row_q > lr) ? '0 : ((col_q > lc) ? lc : col_q);
    kr = (srow_q > lr) ? lr : srow_q;
    kc = (srow_q > lr) ? '0 : ((scol_q > lc) ? lc : scol_q);
  end

  // Plan for the accepted word
  logic [COL_W-1:0] p_col, p_scol, bs_col;
  logic [ROW_W-1:0] p_row, p_srow;
  logic             p_rev, p_wrap, p_shown, p_bell, p_fore, p_back, p_tab;
  esc_e             p_esc;
  logic [7:0]       p_pend, p_color;
  slot_t            p_slot [NSLOT];
  slot_t            lf_s1, lf_s2;
  logic             lf_scroll;

  always_comb begin
    // scroll up by one line at the bottom
    lf_scroll = (fr == lr);
    lf_s1 = mk_slot(lr != '0, 1'b1, 1'b0, '0, ROW_W'(lr - 1'b1), '0, nc, CH_SPACE, 1'b0);
    lf_s2 = mk_slot(1'b1, 1'b0, 1'b0, lr, lr, '0, nc, CH_SPACE, 1'b0);
    bs_col = (fc != '0) ? COL_W'(fc - 1'b1) : '0;

    p_col = fc;  p_row = fr;  p_scol = scol_q;  p_srow = srow_q;
    p_rev = rev_on_q;  p_wrap = wrap_q;  p_shown = shown_q;
    p_esc = esc_q;  p_pend = pend_q;
    p_bell = 1'b0;  p_fore = 1'b0;  p_back = 1'b0;  p_color = '0;  p_tab = 1'b0;
    for (int i = 0; i < NSLOT; i++) p_slot[i] = '0;

    if (!in_op_i) begin
      case (esc_q)
        ESC_LETTER: begin
          p_esc = ESC_GROUND;
          case (in_byte_i)
            KEY_FORE:    p_esc = ESC_FORE;
            KEY_BACK:    p_esc = ESC_BACK;
            KEY_ADDR:    p_esc = ESC_ROW;
            KEY_CLR_BOS: begin
              p_slot[0] = mk_slot(fr != '0, 1'b0, 1'b0, '0, ROW_W'(fr - 1'b1), '0, nc,
                                  CH_SPACE, 1'b0);
              p_slot[1] = mk_slot(fc != '0, 1'b0, 1'b0, fr, fr, '0, (COL_W+1)'(fc),
                                  CH_SPACE, 1'b0);
            end
            KEY_CUR_ON:  p_shown = 1'b1;
            KEY_CUR_OFF: p_shown = 1'b0;
            KEY_SAVE: begin
              p_scol = fc;
              p_srow = fr;
            end
            KEY_REST: begin
              p_col = kc;
              p_row = kr;
            end
            KEY_CLR_LN: begin
              p_slot[0] = mk_slot(1'b1, 1'b0, 1'b0, fr, fr, '0, nc, CH_SPACE, 1'b0);
              p_col = '0;
            end
            KEY_CLR_BOL: p_slot[0] = mk_slot(fc != '0, 1'b0, 1'b0, fr, fr, '0,
                                             (COL_W+1)'(fc), CH_SPACE, 1'b0);
            KEY_REV_ON:  p_rev = 1'b1;
            KEY_REV_OFF: p_rev = 1'b0;
            KEY_WRAP_ON: p_wrap = 1'b1;
            KEY_WRAP_OF: p_wrap = 1'b0;
            KEY_UP:      if (fr != '0) p_row = ROW_W'(fr - 1'b1);
            KEY_DOWN:    if (fr < lr) p_row = ROW_W'(fr + 1'b1);
            KEY_RIGHT:   if (fc < lc) p_col = COL_W'(fc + 1'b1);
            KEY_LEFT:    p_col = bs_col;
            KEY_CLR_ALL: begin
              p_col = '0;
              p_row = '0;
              p_slot[0] = mk_slot(1'b1, 1'b0, 1'b0, '0, lr, '0, nc, CH_SPACE, 1'b0);
            end
            KEY_HOME: begin
              p_col = '0;
              p_row = '0;
            end
            KEY_REV_LF: begin
              if (fr != '0) begin
                p_row = ROW_W'(fr - 1'b1);
              end else begin
                p_slot[0] = mk_slot(lr != '0, 1'b1, 1'b1, lr, ROW_W'(1), '0, nc,
                                    CH_SPACE, 1'b0);
                p_slot[1] = mk_slot(1'b1, 1'b0, 1'b0, '0, '0, '0, nc, CH_SPACE, 1'b0);
              end
            end
            KEY_CLR_EOS: begin
              p_slot[0] = mk_slot(1'b1, 1'b0, 1'b0, fr, fr, fc, nc, CH_SPACE, 1'b0);
              p_slot[1] = mk_slot(fr < lr, 1'b0, 1'b0, ROW_W'(fr + 1'b1), lr, '0, nc,
                                  CH_SPACE, 1'b0);
            end
            KEY_CLR_EOL: p_slot[0] = mk_slot(1'b1, 1'b0, 1'b0, fr, fr, fc, nc,
                                             CH_SPACE, 1'b0);
            KEY_INS_LN: begin
              p_slot[0] = mk_slot(lr > fr, 1'b1, 1'b1, lr, ROW_W'(fr + 1'b1), '0, nc,
                                  CH_SPACE, 1'b0);
              p_slot[1] = mk_slot(1'b1, 1'b0, 1'b0, fr, fr, '0, nc, CH_SPACE, 1'b0);
              p_col = '0;
            end
            KEY_DEL_LN: begin
              p_slot[0] = mk_slot(fr < lr, 1'b1, 1'b0, fr, ROW_W'(lr - 1'b1), '0, nc,
                                  CH_SPACE, 1'b0);
              p_slot[1] = mk_slot(1'b1, 1'b0, 1'b0, lr, lr, '0, nc, CH_SPACE, 1'b0);
              p_col = '0;
            end
            default: ;
          endcase
        end
        ESC_ROW: begin
          p_pend = in_byte_i;
          p_esc  = ESC_COL;
        end
        ESC_COL: begin
          p_col = COL_W'(clamp_coord(in_byte_i, 8'(lc)));
          p_row = ROW_W'(clamp_coord(pend_q, 8'(lr)));
          p_esc = ESC_GROUND;
        end
        ESC_FORE: begin
          p_fore  = 1'b1;
          p_color = in_byte_i;
          p_esc   = ESC_GROUND;
        end
        ESC_BACK: begin
          p_back  = 1'b1;
          p_color = in_byte_i;
          p_esc   = ESC_GROUND;
        end
        default: begin
          p_esc = ESC_GROUND;
          case (in_byte_i)
            CH_ESC: p_esc = ESC_LETTER;
            CH_TAB: begin
              // stop and span length settle in the tab search
              p_tab = 1'b1;
              p_slot[0] = mk_slot(1'b0, 1'b0, 1'b0, fr, fr, fc, '0, CH_SPACE, rev_on_q);
            end
            CH_CR:  p_col = '0;
            CH_LF: begin
              if (!lf_scroll) begin
                p_row = ROW_W'(fr + 1'b1);
              end else begin
                p_slot[1] = lf_s1;
                p_slot[2] = lf_s2;
              end
            end
            CH_BEL: p_bell = 1'b1;
            CH_BS: begin
              p_col = bs_col;
              if (bsov_q) begin
                p_slot[0] = mk_slot(1'b1, 1'b0, 1'b0, fr, fr, bs_col,
                                    (COL_W+1)'(bs_col) + 1'b1, CH_SPACE, rev_on_q);
                // wraps only on a one-column window
                if (bs_col == lc && wrap_q) begin
                  if (!lf_scroll) begin
                    p_row = ROW_W'(fr + 1'b1);
                  end else begin
                    p_slot[1] = lf_s1;
                    p_slot[2] = lf_s2;
                  end
                end
              end
            end
            default: begin
              p_slot[0] = mk_slot(1'b1, 1'b0, 1'b0, fr, fr, fc, (COL_W+1)'(fc) + 1'b1,
                                  in_byte_i, rev_on_q);
              if (fc != lc) begin
                p_col = COL_W'(fc + 1'b1);
              end else if (!wrap_q) begin
                p_col = lc;
              end else begin
                p_col = '0;
                if (!lf_scroll) begin
                  p_row = ROW_W'(fr + 1'b1);
                end else begin
                  p_slot[1] = lf_s1;
                  p_slot[2] = lf_s2;
                end
              end
            end
          endcase
        end
      endcase
    end
  end

  // Current sweep slot
  slot_t            cur;
  logic [ROW_W-1:0] src_row;
  logic [COL_W:0]   swc_inc;
  logic [COL_W-1:0] tab_stop;

  assign cur     = (idx_q >= SLOT_W'(NSLOT)) ? '0 : slot_q[idx_q[$clog2(NSLOT)-1:0]];
  assign src_row = cur.down ? ROW_W'(swr_q - 1'b1) : ROW_W'(swr_q + 1'b1);
  assign swc_inc = (COL_W+1)'(swc_q) + 1'b1;
  assign tab_stop = (acc_q > 9'(lc)) ? lc : COL_W'(acc_q);

  always_comb begin
    stat_o            = '0;
    stat_o.is_read    = is_read_q;
    stat_o.is_tab     = is_tab_q;
    stat_o.tab_end    = acc_q > 9'(col_q);
    stat_o.slot_en    = cur.en;
    stat_o.slot_copy  = cur.copy;
    stat_o.slots_done = (idx_q >= SLOT_W'(NSLOT));
    stat_o.cell_last  = (swc_inc == cur.c1) && (swr_q == cur.rb);
    stat_o.clr_last   = &{swr_q, swc_q};
  end

  // Terminal state and plan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      scol_q    <= '0;
      srow_q    <= '0;
      rev_on_q  <= 1'b0;
      wrap_q    <= 1'b1;
      shown_q   <= 1'b1;
      esc_q     <= ESC_GROUND;
      pend_q    <= '0;
      bell_q    <= 1'b0;
      fore_q    <= 1'b0;
      back_q    <= 1'b0;
      color_q   <= '0;
      is_read_q <= 1'b0;
      is_tab_q  <= 1'b0;
      idx_q     <= '0;
      acc_q     <= '0;
      for (int i = 0; i < NSLOT; i++) slot_q[i] <= '0;
    end else begin
      if (cmd_i.load) begin
        col_q     <= p_col;
        row_q     <= p_row;
        scol_q    <= p_scol;
        srow_q    <= p_srow;
        rev_on_q  <= p_rev;
        wrap_q    <= p_wrap;
        shown_q   <= p_shown;
        esc_q     <= p_esc;
        pend_q    <= p_pend;
        bell_q    <= p_bell;
        fore_q    <= p_fore;
        back_q    <= p_back;
        color_q   <= p_color;
        is_read_q <= in_op_i;
        is_tab_q  <= p_tab;
        idx_q     <= '0;
        acc_q     <= '0;
        for (int i = 0; i < NSLOT; i++) slot_q[i] <= in_op_i ? '0 : p_slot[i];
      end
      if (cmd_i.tab_step) acc_q <= acc_q + 9'(tw);
      if (cmd_i.tab_done) begin
        col_q        <= tab_stop;
        slot_q[0].c1 <= (COL_W+1)'(tab_stop);
        slot_q[0].en <= tabov_q && (tab_stop > col_q);
      end
      if (cmd_i.slot_next) idx_q <= SLOT_W'(idx_q + 1'b1);
    end
  end

  // Sweep counters, also walk the store once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swr_q <= '0;
      swc_q <= '0;
    end else if (cmd_i.clr_wr) begin
      {swr_q, swc_q} <= ADDR_W'({swr_q, swc_q} + 1'b1);
    end else if (cmd_i.sw_start) begin
      swr_q <= cur.ra;
      swc_q <= cur.c0;
    end else if (cmd_i.fill_wr || cmd_i.copy_wr) begin
      if (swc_inc == cur.c1) begin
        swc_q <= cur.c0;
        swr_q <= src_row;
      end else begin
        swc_q <= COL_W'(swc_inc);
      end
    end
  end

  // Screen store: {reverse, character}
  logic [CELL_W-1:0] mem [MAX_ROWS*MAX_COLS];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic [CELL_W-1:0] mem_wd;

  assign mem_we = cmd_i.clr_wr || cmd_i.fill_wr || cmd_i.copy_wr;
  assign mem_re = cmd_i.load || cmd_i.copy_rd;
  assign mem_ra = cmd_i.load ? {in_row_i, in_col_i} : {src_row, swc_q};

  always_comb begin
    if (cmd_i.copy_wr)      mem_wd = rdata_q;
    else if (cmd_i.fill_wr) mem_wd = {cur.rev, cur.ch};
    else                    mem_wd = {1'b0, CH_SPACE};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[{swr_q, swc_q}] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {6'b0,
                is_read_q & rdata_q[8],
                is_read_q ? rdata_q[7:0] : 8'h00,
                color_q, back_q, fore_q, bell_q,
                (esc_q != ESC_GROUND), shown_q, row_q, col_q};
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

FILE: design/vte_checker.sv
// Port-level checks for the VT52 terminal engine, bound to the top level.
`default_nettype none
module vte_checker import vte_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a bell byte is handled in ground state and leaves no escape open
  a_bell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> !m_axis_tdata[13] && !m_axis_tdata[15]
                                          && !m_axis_tdata[16])
    else $error("bell with escape or colour");

  // one colour kind at a time, and the escape ends with it
  a_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15] || m_axis_tdata[16]) |->
      !(m_axis_tdata[15] && m_axis_tdata[16]) && !m_axis_tdata[13])
    else $error("bad colour flags");

  // colour value only accompanies a colour set
  a_cval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[15] && !m_axis_tdata[16] |-> m_axis_tdata[24:17] == 8'h00)
    else $error("stray colour value");

endmodule

bind vt52_terminal_engine_core vte_checker u_vte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
